// File: rtl/tch_pkg.sv
// Shared types, constants and the arctangent table for the tilt-compensated heading block.
// Depends on nothing; every module in rtl/ imports it.
package tch_pkg;

  localparam int TABLE_LEN = 24;
  localparam int ANG_W     = 34;   // Q30 angles up to about +-2*pi
  localparam int VEC_W     = 58;   // horizontal field vector in the vectoring chain
  localparam int TRIG_W    = 18;   // Q15 sine and cosine
  localparam int MAG_W     = 17;   // offset-corrected field
  localparam int PROD1_W   = MAG_W + TRIG_W;
  localparam int PROD2_W   = PROD1_W + TRIG_W;
  localparam int NORM_TOP  = 48;   // normalize the larger magnitude up to just below 2^48

  localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 34'sd6746518852;
  localparam logic signed [ANG_W-1:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] FULL_TURN   = 34'sd51472;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                    neg;
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [MAG_W-1:0] mx;
    logic signed [MAG_W-1:0] my;
    logic signed [MAG_W-1:0] mz;
  } mag_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/tilt_compensated_heading.sv
// Tilt-compensated compass heading, fully pipelined chain of CORDIC cells.
// One request per cycle while the output is not stalled; a full, refused output register holds the pipeline.
// Every rotation and vectoring step is its own cell.
// Synchronous active-high reset clears the offsets to zero and empties the valid pipeline.
// Depends on tch_pkg, tch_rot_cell, tch_norm_cell and tch_vec_cell.
module tilt_compensated_heading #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample request channel
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] field_x,
  input  logic signed [15:0] field_y,
  input  logic signed [15:0] field_z,
  // heading result channel
  output logic        heading_valid,
  input  logic        heading_ready,
  output logic [15:0] heading
);
  import tch_pkg::*;

  // The step count saturates at the length of the arctangent table.
  localparam int NS  = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int LAT = 2 * NS + 13;

  // Configuration registers. Writes are taken in the access phase of the port.
  logic signed [15:0] offset_x, offset_y, offset_z;
  reg_idx_t           widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_OFFSET_X: offset_x <= pwdata[15:0];
        REG_OFFSET_Y: offset_y <= pwdata[15:0];
        REG_OFFSET_Z: offset_z <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_OFFSET_X: prdata = 32'(offset_x);
      REG_OFFSET_Y: prdata = 32'(offset_y);
      REG_OFFSET_Z: prdata = 32'(offset_z);
      default:      prdata = '0;
    endcase
  end

  // The whole pipeline advances together; it stalls only when the output
  // register is full and the consumer is not taking it.
  logic           en;
  logic [LAT-1:0] vld;

  assign en            = !vld[LAT-1] || heading_ready;
  assign sample_ready  = en;
  assign heading_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], sample_valid};
    end
  end

  // Input stage: scale the angles to Q30 and fold anything beyond +-pi/2
  // back by pi, remembering to negate the sine and cosine afterwards.
  // The hard-iron offsets are removed here too.
  rot_t rr [0:NS];
  rot_t rp [0:NS];
  mag_t md [0:NS];

  function automatic rot_t fold(input logic signed [15:0] a);
    rot_t                    r;
    logic signed [ANG_W-1:0] z;
    z     = ANG_W'(a) <<< 17;
    r.x   = CORDIC_X0;
    r.y   = '0;
    r.neg = 1'b0;
    r.z   = z;
    if (z > Q30_HALF_PI) begin
      r.z   = z - Q30_PI;
      r.neg = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      r.z   = z + Q30_PI;
      r.neg = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0]    <= fold(roll_angle);
      rp[0]    <= fold(pitch_angle);
      md[0].mx <= MAG_W'(field_x) - MAG_W'(offset_x);
      md[0].my <= MAG_W'(field_y) - MAG_W'(offset_y);
      md[0].mz <= MAG_W'(field_z) - MAG_W'(offset_z);
    end
  end

  // Two parallel rotation chains give sine and cosine of roll and pitch;
  // the corrected field rides alongside in a plain delay line.
  for (genvar i = 0; i < NS; i++) begin : g_rot
    tch_rot_cell #(.IDX(i)) u_roll (.clk(clk), .en(en), .d(rr[i]), .q(rr[i+1]));
    tch_rot_cell #(.IDX(i)) u_pitch (.clk(clk), .en(en), .d(rp[i]), .q(rp[i+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        md[i+1] <= md[i];
      end
    end
  end

  // Round to Q15, undoing the fold with a sign flip.
  function automatic logic signed [TRIG_W-1:0] q15(input logic signed [ANG_W-1:0] v,
                                                   input logic neg);
    logic signed [ANG_W-1:0] s;
    logic signed [ANG_W-1:0] r;
    s = neg ? -v : v;
    r = (s + ANG_W'(16384)) >>> 15;
    return r[TRIG_W-1:0];
  endfunction

  logic signed [TRIG_W-1:0] sr, cr, sp, cp;
  mag_t                     m1;

  always_ff @(posedge clk) begin
    if (en) begin
      sr <= q15(rr[NS].y, rr[NS].neg);
      cr <= q15(rr[NS].x, rr[NS].neg);
      sp <= q15(rp[NS].y, rp[NS].neg);
      cp <= q15(rp[NS].x, rp[NS].neg);
      m1 <= md[NS];
    end
  end

  // First products of the tilt rotation.
  logic signed [PROD1_W-1:0] p1, p2, p3, p4, p5;
  logic signed [TRIG_W-1:0]  sr2, cr2;

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= PROD1_W'(m1.my) * PROD1_W'(cr);
      p2  <= PROD1_W'(m1.mz) * PROD1_W'(sr);
      p3  <= PROD1_W'(m1.mx) * PROD1_W'(cp);
      p4  <= PROD1_W'(m1.my) * PROD1_W'(sp);
      p5  <= PROD1_W'(m1.mz) * PROD1_W'(sp);
      sr2 <= sr;
      cr2 <= cr;
    end
  end

  // Second products, and the first horizontal component.
  logic signed [VEC_W-1:0]   h1;
  logic signed [PROD2_W-1:0] q1, q2;
  logic signed [PROD1_W-1:0] p3d;

  always_ff @(posedge clk) begin
    if (en) begin
      h1  <= (VEC_W'(p1) + VEC_W'(p2)) <<< 15;
      q1  <= PROD2_W'(p4) * PROD2_W'(sr2);
      q2  <= PROD2_W'(p5) * PROD2_W'(cr2);
      p3d <= p3;
    end
  end

  // The heading is the angle of the vector (h2, -h1).
  vec_t nv [0:6];
  logic signed [VEC_W-1:0] h2;

  assign h2 = (VEC_W'(p3d) <<< 15) + VEC_W'(q1) - VEC_W'(q2);

  always_ff @(posedge clk) begin
    if (en) begin
      nv[0].x    <= h2;
      nv[0].y    <= -h1;
      nv[0].z    <= '0;
      nv[0].zero <= (h2 == '0) && (h1 == '0);
    end
  end

  // Normalization by binary shift steps of 32, 16, 8, 4, 2 and 1.
  for (genvar k = 0; k < 6; k++) begin : g_norm
    tch_norm_cell #(.SH(32 >> k)) u_norm (.clk(clk), .en(en), .d(nv[k]), .q(nv[k+1]));
  end

  // A vector in the left half-plane is turned by pi before vectoring.
  vec_t vv [0:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      vv[0].zero <= nv[6].zero;
      if (nv[6].x < 0) begin
        vv[0].x <= -nv[6].x;
        vv[0].y <= -nv[6].y;
        vv[0].z <= Q30_PI;
      end else begin
        vv[0].x <= nv[6].x;
        vv[0].y <= nv[6].y;
        vv[0].z <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    tch_vec_cell #(.IDX(i)) u_vec (.clk(clk), .en(en), .d(vv[i]), .q(vv[i+1]));
  end

  // Wrap into [0, 2*pi), round to Q3.13, and fold a rounded full turn or a zero vector to zero.
  logic signed [ANG_W-1:0] zw, zq;

  assign zw = (vv[NS].z < 0) ? vv[NS].z + Q30_TWO_PI : vv[NS].z;
  assign zq = (zw + ANG_W'(65536)) >>> 17;

  always_ff @(posedge clk) begin
    if (en) begin
      if (vv[NS].zero || zq >= FULL_TURN || zq < 0) begin
        heading <= '0;
      end else begin
        heading <= zq[15:0];
      end
    end
  end

  // A delivered heading always lies inside one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    heading_valid |-> (34'(heading) < FULL_TURN))
    else $error("heading outside one turn");

  // The valid pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !heading_valid)
    else $error("result present after reset");

  // A stall holds the output register: nothing new can enter while it is full and refused.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (heading_valid && !heading_ready) |=> $stable(heading))
    else $error("output changed during a stall");

endmodule

// File: rtl/tch_rot_cell.sv
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on tch_pkg for rot_t and the arctangent table.
module tch_rot_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  tch_pkg::rot_t d,
  output tch_pkg::rot_t q
);
  import tch_pkg::*;

  logic signed [ANG_W-1:0] xs, ys;

  assign xs = d.x >>> IDX;
  assign ys = d.y >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      q.neg <= d.neg;
      if (d.z >= 0) begin
        q.x <= d.x - ys;
        q.y <= d.y + xs;
        q.z <= d.z - atan_q30(IDX);
      end else begin
        q.x <= d.x + ys;
        q.y <= d.y - xs;
        q.z <= d.z + atan_q30(IDX);
      end
    end
  end
endmodule

// File: rtl/tch_norm_cell.sv
// One normalization step: doubles the vector SH times when both magnitudes stay small.
// Depends on tch_pkg for vec_t.
module tch_norm_cell #(
  parameter int SH = 1
) (
  input  logic          clk,
  input  logic          en,
  input  tch_pkg::vec_t d,
  output tch_pkg::vec_t q
);
  import tch_pkg::*;

  localparam logic [VEC_W-1:0] LIMIT = VEC_W'(1) << (NORM_TOP - SH);

  logic [VEC_W-1:0] ax, ay;
  logic             small_vec;

  assign ax        = d.x[VEC_W-1] ? VEC_W'(-d.x) : VEC_W'(d.x);
  assign ay        = d.y[VEC_W-1] ? VEC_W'(-d.y) : VEC_W'(d.y);
  assign small_vec = (ax < LIMIT) && (ay < LIMIT);

  always_ff @(posedge clk) begin
    if (en) begin
      q.zero <= d.zero;
      q.z    <= d.z;
      if (small_vec) begin
        q.x <= d.x <<< SH;
        q.y <= d.y <<< SH;
      end else begin
        q.x <= d.x;
        q.y <= d.y;
      end
    end
  end
endmodule

// File: rtl/tch_vec_cell.sv
// One vectoring-mode CORDIC micro-rotation, registered.
// Depends on tch_pkg for vec_t and the arctangent table.
module tch_vec_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          en,
  input  tch_pkg::vec_t d,
  output tch_pkg::vec_t q
);
  import tch_pkg::*;

  logic signed [VEC_W-1:0] xs, ys;

  assign xs = d.x >>> IDX;
  assign ys = d.y >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      q.zero <= d.zero;
      if (d.y >= 0) begin
        q.x <= d.x + ys;
        q.y <= d.y - xs;
        q.z <= d.z + atan_q30(IDX);
      end else begin
        q.x <= d.x - ys;
        q.y <= d.y + xs;
        q.z <= d.z - atan_q30(IDX);
      end
    end
  end
endmodule
